### rtl/speaker_toggle_pcm_sampler_assert.svh
// Assertion macros for the speaker toggle PCM sampler.
// Included by the RTL modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef SPEAKER_TOGGLE_PCM_SAMPLER_ASSERT_SVH
`define SPEAKER_TOGGLE_PCM_SAMPLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define STS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sampler check failed");
// Next-cycle implication, checked out of reset.
`define STS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sampler check failed");
`else
`define STS_ASSERT_IMP(lbl, ante, cons)
`define STS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/sts_pkg.sv
// Shared types and constants for the speaker toggle PCM sampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sts_pkg;

    // Register map (register index = byte address / 4).
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [2:0] REG_QUIET_LIMIT   = 3'd1;
    localparam logic [2:0] REG_AMPLITUDE     = 3'd2;
    localparam logic [2:0] REG_FRAME_CAP     = 3'd3;
    localparam logic [2:0] REG_NORMAL_SPEED  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd5924;
    localparam logic [15:0] RST_QUIET_LIMIT   = 16'd51;
    localparam logic [14:0] RST_AMPLITUDE     = 15'd8192;
    localparam logic [11:0] RST_FRAME_CAP     = 12'd735;

    // One CPU tick in 8.8 fixed point, which is also the shortest period.
    localparam logic [16:0] ONE_CYCLE  = 17'd256;
    localparam logic [16:0] MIN_PERIOD = 17'd256;
    localparam logic [15:0] QUIET_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [15:0] sample_period;
        logic [15:0] quiet_limit;
        logic [14:0] amplitude;
        logic [11:0] frame_sample_cap;
        logic        normal_speed;
    } t_cfg;

    typedef struct packed {
        logic speaker_access;
        logic frame_end;
    } t_item;

    typedef struct packed {
        logic        has_sample;
        logic [15:0] sample_value;
        logic        end_of_frame;
        logic [11:0] frame_samples;
    } t_result;

endpackage

### rtl/speaker_toggle_pcm_sampler.sv
// Speaker toggle PCM sampler: converts per-tick speaker accesses into a PCM sample stream.
// The input item flows from an input register through the core update into a result register.
// Each accepted item carries speaker_access in s_axis_tdata[0] and frame_end on s_axis_tlast.
// Results carry has_sample on m_axis_tuser, end_of_frame on m_axis_tlast, and
// sample_value and frame_samples in m_axis_tdata.
// Ticks that produce neither a sample nor a frame end give no result but still advance
// the sampler state. A result is registered as its held item leaves the input register.
// Throughput is one item per cycle unless a stall in the output register holds the input;
// the next item is taken while a result waits in the output register.
// When the receiver stalls, a finished result holds in the output register; the input
// register then fills, and s_axis_tready drops only once a result-producing item waits
// behind it. Items without a result still pass through during a stall.
// Synchronous reset clears the phase, polarity, mute, quiet timer and frame count, empties
// both registers, and loads the configuration reset values. The user must write configuration
// registers through the APB port only while no item is in flight; no logic enforces it.
// Depends on sts_pkg, sts_cfg, sts_core and the assertion macro header.
`timescale 1ns / 1ps

module speaker_toggle_pcm_sampler #(
    parameter int unsigned COUNT_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input stream.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [0] speaker_access, [7:1] zero
    input  logic                       s_axis_tlast,  // frame_end
    // Result stream.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,  // [15:0] sample_value,
                                                      // [27:16] frame_samples, [31:28] zero
    output logic                       m_axis_tuser,  // has_sample
    output logic                       m_axis_tlast,  // end_of_frame
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sts_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import sts_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    logic    w_emit;
    logic    w_adv;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    sts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sts_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res),
        .o_emit  (w_emit)
    );

    // The held item moves on unless it has a result and the output register is blocked.
    assign w_adv         = r_in_valid && (!w_emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.speaker_access <= s_axis_tdata[0];
            r_in_item.frame_end      <= s_axis_tlast;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.frame_samples, r_out.sample_value};
    assign m_axis_tuser  = r_out.has_sample;
    assign m_axis_tlast  = r_out.end_of_frame;

`include "speaker_toggle_pcm_sampler_assert.svh"

    // Every delivered result carries a sample or a frame marker.
    `STS_ASSERT_IMP(a_result_nonempty, m_axis_tvalid, m_axis_tuser || m_axis_tlast)
    // Fields without their flag read as zero.
    `STS_ASSERT_IMP(a_sample_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:0] == 16'd0)
    `STS_ASSERT_IMP(a_count_zero, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[27:16] == 12'd0)
    // The held item only waits on a stalled, occupied result register.
    `STS_ASSERT_IMP(a_stall_cause, r_in_valid && !w_adv, r_out_valid && !m_axis_tready)

endmodule

### rtl/sts_cfg.sv
// APB configuration register file for the speaker toggle PCM sampler.
// Depends on sts_pkg for the register map and reset values.
`timescale 1ns / 1ps

module sts_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sts_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output sts_pkg::t_cfg              o_cfg
);
    import sts_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // Register writes on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period    <= RST_SAMPLE_PERIOD;
            r_cfg.quiet_limit      <= RST_QUIET_LIMIT;
            r_cfg.amplitude        <= RST_AMPLITUDE;
            r_cfg.frame_sample_cap <= RST_FRAME_CAP;
            r_cfg.normal_speed     <= 1'b1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SAMPLE_PERIOD: r_cfg.sample_period    <= pwdata[15:0];
                REG_QUIET_LIMIT:   r_cfg.quiet_limit      <= pwdata[15:0];
                REG_AMPLITUDE:     r_cfg.amplitude        <= pwdata[14:0];
                REG_FRAME_CAP:     r_cfg.frame_sample_cap <= pwdata[11:0];
                REG_NORMAL_SPEED:  r_cfg.normal_speed     <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Read-back mux; unmapped addresses read as zero.
    always_comb begin
        unique case (w_idx)
            REG_SAMPLE_PERIOD: prdata = {16'd0, r_cfg.sample_period};
            REG_QUIET_LIMIT:   prdata = {16'd0, r_cfg.quiet_limit};
            REG_AMPLITUDE:     prdata = {17'd0, r_cfg.amplitude};
            REG_FRAME_CAP:     prdata = {20'd0, r_cfg.frame_sample_cap};
            REG_NORMAL_SPEED:  prdata = {31'd0, r_cfg.normal_speed};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

### rtl/sts_core.sv
// Sampler state and per-tick update: phase accumulator, polarity, quiet timer, frame count.
// Depends on sts_pkg and the assertion macro header.
`timescale 1ns / 1ps

module sts_core #(
    parameter int unsigned COUNT_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  sts_pkg::t_item   i_item,
    input  sts_pkg::t_cfg    i_cfg,
    output sts_pkg::t_result o_res,
    output logic             o_emit
);
    import sts_pkg::*;

    localparam int unsigned CMP_W = COUNT_BITS + 12;

    logic [15:0]           r_phase;
    logic                  r_neg;
    logic                  r_muted;
    logic                  r_toggled;
    logic                  r_armed;
    logic [15:0]           r_quiet;
    logic [COUNT_BITS-1:0] r_fcount;

    logic [15:0]           n_phase;
    logic                  n_neg;
    logic                  n_muted;
    logic                  n_toggled;
    logic                  n_armed;
    logic [15:0]           n_quiet;
    logic [COUNT_BITS-1:0] n_fcount;

    logic                  w_en;
    logic                  w_access;
    logic [16:0]           w_period;
    logic [16:0]           w_acc;
    logic                  w_keep;
    logic [CMP_W-1:0]      w_closed_ext;
    t_result               w_res;

    assign w_en     = i_cfg.normal_speed;
    assign w_access = w_en && i_item.speaker_access;

    // Next state in the order of one tick: unmute, sample, toggle, quiet timer, frame end.
    always_comb begin
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_muted      = r_muted;
        n_toggled    = r_toggled;
        n_armed      = r_armed;
        n_quiet      = r_quiet;
        n_fcount     = r_fcount;
        w_res        = '0;
        w_closed_ext = '0;

        if (w_access) begin
            n_muted = 1'b0;
        end

        // Phase step; a period below one tick acts as one tick.
        w_period = ({1'b0, i_cfg.sample_period} < MIN_PERIOD) ? MIN_PERIOD
                 : {1'b0, i_cfg.sample_period};
        w_acc    = {1'b0, r_phase} + ONE_CYCLE;
        w_keep   = {{12{1'b0}}, r_fcount} < {{COUNT_BITS{1'b0}}, i_cfg.frame_sample_cap};
        if (w_acc >= w_period) begin
            w_acc = w_acc - w_period;
            if (w_en && w_keep) begin
                w_res.has_sample = 1'b1;
                if (n_muted) begin
                    w_res.sample_value = 16'd0;
                end else if (r_neg) begin
                    w_res.sample_value = 16'd0 - {1'b0, i_cfg.amplitude};
                end else begin
                    w_res.sample_value = {1'b0, i_cfg.amplitude};
                end
                n_fcount = r_fcount + 1'b1;
            end
        end
        n_phase = w_acc[15:0];

        // A speaker access flips polarity and disarms the quiet timer.
        if (w_access) begin
            n_neg     = !r_neg;
            n_toggled = 1'b1;
            n_armed   = 1'b0;
            n_quiet   = 16'd0;
        end

        // Quiet timer saturates and mutes from the next sample on.
        if (n_armed) begin
            if (n_quiet != QUIET_MAX) begin
                n_quiet = n_quiet + 16'd1;
            end
            if (n_quiet > i_cfg.quiet_limit) begin
                n_muted = 1'b1;
            end
        end

        // Frame end closes the count and arms the timer after a silent frame.
        if (i_item.frame_end) begin
            w_closed_ext        = {{12{1'b0}}, n_fcount};
            w_res.end_of_frame  = 1'b1;
            w_res.frame_samples = w_closed_ext[11:0];
            n_fcount            = '0;
            if (n_toggled) begin
                n_toggled = 1'b0;
            end else if (!n_armed) begin
                n_armed = 1'b1;
                n_quiet = 16'd0;
            end
        end
    end

    assign o_res  = w_res;
    assign o_emit = w_en && (w_res.has_sample || w_res.end_of_frame);

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 16'd0;
            r_neg     <= 1'b0;
            r_muted   <= 1'b0;
            r_toggled <= 1'b0;
            r_armed   <= 1'b0;
            r_quiet   <= 16'd0;
            r_fcount  <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_muted   <= n_muted;
            r_toggled <= n_toggled;
            r_armed   <= n_armed;
            r_quiet   <= n_quiet;
            r_fcount  <= n_fcount;
        end
    end

`include "speaker_toggle_pcm_sampler_assert.svh"

    // The quiet count only moves while the timer is armed.
    `STS_ASSERT_IMP(a_quiet_only_armed, r_quiet != 16'd0, r_armed)
    // An armed timer and a pending toggle exclude each other.
    `STS_ASSERT_IMP(a_armed_not_toggled, r_armed, !r_toggled)
    // A stepped access always leaves the speaker unmuted.
    `STS_ASSERT_NXT(a_access_unmutes, i_step && w_access, !r_muted)

endmodule

### bench/speaker_toggle_pcm_sampler_tb.sv
// Self-checking testbench for the speaker toggle PCM sampler.
// Drives CPU ticks on the input stream and registers over the APB port; needs sts_pkg and the RTL.
// A scoreboard class predicts each tick's result and checks the output stream in order.
`timescale 1ns / 1ps

module speaker_toggle_pcm_sampler_tb;

    import sts_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PHASE_ITEMS    = 130;

    // Predicts the sampler tick by tick and holds the results still to come.
    class pcm_scoreboard;
        t_cfg        cfg;
        logic [15:0] phase;
        bit          level_neg;
        bit          muted;
        bit          toggled;
        bit          quiet_armed;
        logic [15:0] quiet_count;
        logic [11:0] frame_count;
        t_result     pending_samples[$];
        int          errors;

        function new();
            cfg.sample_period    = RST_SAMPLE_PERIOD;
            cfg.quiet_limit      = RST_QUIET_LIMIT;
            cfg.amplitude        = RST_AMPLITUDE;
            cfg.frame_sample_cap = RST_FRAME_CAP;
            cfg.normal_speed     = 1'b1;
            phase       = '0;
            level_neg   = 1'b0;
            muted       = 1'b0;
            toggled     = 1'b0;
            quiet_armed = 1'b0;
            quiet_count = '0;
            frame_count = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_SAMPLE_PERIOD: cfg.sample_period    = val[15:0];
                REG_QUIET_LIMIT:   cfg.quiet_limit      = val[15:0];
                REG_AMPLITUDE:     cfg.amplitude        = val[14:0];
                REG_FRAME_CAP:     cfg.frame_sample_cap = val[11:0];
                REG_NORMAL_SPEED:  cfg.normal_speed     = val[0];
                default: ;
            endcase
        endfunction

        function int pending_count();
            return pending_samples.size();
        endfunction

        // Advances the sampler state by one CPU tick.
        function void predict_tick(bit access_in, bit frame_end);
            bit          enabled;
            bit          access;
            bit          has;
            logic [16:0] period;
            logic [16:0] acc;
            logic [15:0] value;
            logic [11:0] closed;
            t_result     res;
            enabled = cfg.normal_speed;
            access  = enabled && access_in;
            has     = 1'b0;
            value   = '0;
            closed  = '0;
            period  = (cfg.sample_period < 16'd256) ? MIN_PERIOD : {1'b0, cfg.sample_period};

            if (access) begin
                muted = 1'b0;
            end

            // Phase step; a due sample is kept only below the frame cap.
            acc = {1'b0, phase} + ONE_CYCLE;
            if (acc >= period) begin
                acc = acc - period;
                if (enabled && frame_count < cfg.frame_sample_cap) begin
                    has = 1'b1;
                    if (muted) begin
                        value = '0;
                    end else if (level_neg) begin
                        value = 16'h0000 - {1'b0, cfg.amplitude};
                    end else begin
                        value = {1'b0, cfg.amplitude};
                    end
                    frame_count = frame_count + 12'd1;
                end
            end
            phase = acc[15:0];

            // The access flips polarity after this tick's sample was taken.
            if (access) begin
                level_neg   = ~level_neg;
                toggled     = 1'b1;
                quiet_armed = 1'b0;
                quiet_count = '0;
            end

            if (quiet_armed) begin
                if (quiet_count != QUIET_MAX) begin
                    quiet_count = quiet_count + 16'd1;
                end
                if (quiet_count > cfg.quiet_limit) begin
                    muted = 1'b1;
                end
            end

            // Frame close; a frame without any access arms the quiet timer.
            if (frame_end) begin
                closed      = frame_count;
                frame_count = '0;
                if (toggled) begin
                    toggled = 1'b0;
                end else if (!quiet_armed) begin
                    quiet_armed = 1'b1;
                    quiet_count = '0;
                end
            end

            if (enabled && (has || frame_end)) begin
                res.has_sample    = has;
                res.sample_value  = value;
                res.end_of_frame  = frame_end;
                res.frame_samples = frame_end ? closed : 12'd0;
                pending_samples.push_back(res);
            end
        endfunction

        function void check_field(string field, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, exp_v, act_v);
            end
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_sample(t_result got);
            t_result exp_r;
            if (pending_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                exp_r = pending_samples.pop_front();
                check_field("has_sample", exp_r.has_sample, got.has_sample);
                check_field("sample_value", int'($signed(exp_r.sample_value)),
                            int'($signed(got.sample_value)));
                check_field("end_of_frame", exp_r.end_of_frame, got.end_of_frame);
                check_field("frame_samples", exp_r.frame_samples, got.frame_samples);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;   // [0] speaker_access, [7:1] zero
    logic                s_axis_tlast = 1'b0; // frame_end
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b1;
    logic [31:0]         m_axis_tdata;        // [15:0] sample_value, [27:16] frame_samples
    logic                m_axis_tuser;        // has_sample
    logic                m_axis_tlast;        // end_of_frame
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    pcm_scoreboard sb;
    t_result       mon_result;
    bit            tx_gappy = 1'b0;
    bit            rx_gappy = 1'b0;
    int unsigned   stall_left = 0;
    int unsigned   idle_cycles = 0;

    speaker_toggle_pcm_sampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap(bit gappy);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gappy || r < 70) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = pick_gap(rx_gappy);
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_result.has_sample    = m_axis_tuser;
            mon_result.sample_value  = m_axis_tdata[15:0];
            mon_result.end_of_frame  = m_axis_tlast;
            mon_result.frame_samples = m_axis_tdata[27:16];
            sb.check_sample(mon_result);
        end
    end

    // Watchdog on cycles in which no request of any kind completes.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one CPU tick; called and returning at a falling edge.
    task automatic send_tick(bit access, bit frame_end);
        int unsigned gap;
        gap = pick_gap(tx_gappy);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, access};
        s_axis_tlast  <= frame_end;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.predict_tick(access, frame_end);
        @(negedge i_clk);
    endtask

    // Waits for every predicted result, then for ticks without results to leave the pipe.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [15:0] period, logic [15:0] qlimit, logic [14:0] amp,
                              logic [11:0] cap, bit speed);
        wait_idle();
        write_reg(REG_SAMPLE_PERIOD, {16'd0, period});
        write_reg(REG_QUIET_LIMIT, {16'd0, qlimit});
        write_reg(REG_AMPLITUDE, {17'd0, amp});
        write_reg(REG_FRAME_CAP, {20'd0, cap});
        write_reg(REG_NORMAL_SPEED, {31'd0, speed});
    endtask

    // Random frames: silent, sparse and busy frames, plus some frames of noise
    // with frame ends at random places.
    task automatic play_frames(int unsigned n_items, bit allow_idle);
        int unsigned sent;
        int unsigned len;
        int unsigned style;
        int unsigned access_pct;
        bit          fe;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
            // The last frame of a phase is cut to the remaining item budget.
            if (len > n_items - sent) begin
                len = n_items - sent;
            end
            style = $urandom_range(0, 9);
            access_pct = (style < 3) ? 0 : (style < 6) ? 5 : (style < 9) ? 40 : 50;
            tx_gappy = allow_idle && ($urandom_range(0, 3) != 0);
            rx_gappy = allow_idle && ($urandom_range(0, 3) != 0);
            for (int unsigned k = 0; k < len; k++) begin
                fe = (style == 9) ? ($urandom_range(0, 9) == 0) : (k == len - 1);
                send_tick($urandom_range(0, 99) < access_pct, fe);
            end
            sent += len;
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Shortest period, full amplitude, tiny cap: cap drop, quiet mute and unmute.
        set_config(16'd0, 16'd2, 15'd32767, 12'd3, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        repeat (4) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);

        // Period below one tick, zero amplitude and zero cap.
        set_config(16'd100, 16'd0, 15'd0, 12'd0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);

        // Longest period builds up phase, then a shorter period drains it.
        set_config(16'hFFFF, 16'hFFFF, 15'd1, 12'd4095, 1'b1);
        repeat (6) send_tick(1'b0, 1'b0);
        set_config(16'd300, 16'hFFFF, 15'd1, 12'd4095, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);

        // Slow mode drops accesses and all results.
        set_config(16'd256, 16'd5, 15'd1000, 12'd100, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);

        // Random phases, each under its own register setting.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(16'd256, 16'($urandom_range(0, 8)), 15'd32767,
                              12'($urandom_range(1, 12)), 1'b1);
                1: set_config(16'($urandom_range(257, 1200)), 16'd0, 15'd0, 12'd4095, 1'b1);
                2: set_config(16'($urandom_range(0, 255)), 16'($urandom_range(0, 30)),
                              15'($urandom), 12'($urandom_range(1, 30)), 1'b1);
                3: set_config(16'hFFFF, 16'hFFFF, 15'($urandom),
                              12'($urandom_range(1, 4095)), 1'b1);
                4: set_config(16'($urandom_range(256, 700)), 16'($urandom_range(0, 20)),
                              15'($urandom), 12'd0, 1'b1);
                5: set_config(16'($urandom_range(256, 2000)), 16'($urandom_range(0, 20)),
                              15'($urandom), 12'($urandom_range(1, 40)), 1'b0);
                6: set_config(16'($urandom_range(256, 800)), 16'($urandom_range(0, 40)),
                              15'($urandom), 12'($urandom_range(1, 20)), 1'b1);
                default: set_config(16'd256, 16'($urandom_range(0, 5)), 15'($urandom),
                                    12'($urandom_range(1, 4095)), 1'b1);
            endcase
            play_frames(PHASE_ITEMS, p != 2);
        end

        // Drain and report.
        wait_idle();
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
